>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

>>> rtl/core/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// fpalu_pkg
// commands and status codes of the fixed point alu
// ----------------------------------------------------------------------------
package fpalu_pkg;

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_SUB    = 3'd1,
		CMD_MUL    = 3'd2,
		CMD_DIV    = 3'd3,
		CMD_SQUARE = 3'd4,
		CMD_ROOT   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_NEG_ROOT = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	localparam int unsigned WORD_W = 32;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

endpackage

>>> rtl/core/fixed_point_calculator_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_calculator_alu
// pipelined signed fixed point alu: add, sub, mul, div, square, square root
// ----------------------------------------------------------------------------
//
// channel | dir | tdata                                  | tuser
// s_*     | in  | [31:0] operand_a, [63:32] operand_b    | [2:0] command
// m_*     | out | [31:0] result_value, [33:32] status    | -
//
// one beat enters per cycle while s_tready is high; the pipe depth is set by
// the restoring divider, which resolves one quotient bit per stage over
// 32 + FRACTION_BITS stages; the root shares those stages at one result bit
// per stage
// the whole pipe advances together; a skid register after the last stage
// holds a result that is not taken, and s_tready drops only while it is full
// reset clears the valid bits and the skid flag, payload is not reset
//
module fixed_point_calculator_alu #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
	input  logic [2:0]  s_tuser,   // [2:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] result_value, [33:32] status, rest zero
);

	localparam int unsigned W  = fpalu_pkg::WORD_W;
	localparam int unsigned DW = W + FRACTION_BITS;      // dividend / quotient width
	localparam int unsigned SW = (DW + 1) / 2;           // root width
	localparam int unsigned L  = DW;                     // iteration stages
	localparam int unsigned N  = L + 2;                  // last stage index

	// per-stage pipeline registers, index is the stage number
	logic                     vld_s   [1:N];
	fpalu_pkg::cmd_t          cmd_s   [1:N];
	logic signed [W-1:0]      res_s   [1:N];
	fpalu_pkg::status_t       st_s    [1:N];
	logic [W-1:0]             drem_s  [1:N];   // divider remainder
	logic [DW-1:0]            dnq_s   [1:N];   // dividend bits out, quotient bits in
	logic [W-1:0]             dden_s  [1:N];   // divisor magnitude
	logic                     dneg_s  [1:N];
	logic [SW+1:0]            srem_s  [1:N];   // root remainder
	logic [SW-1:0]            sroot_s [1:N];
	logic [2*SW-1:0]          snum_s  [1:N];   // radicand, two bits out per step
	logic signed [2*W-1:0]    prod_s2;
	logic signed [W-1:0]      mb_s1;
	// operand a kept signed for the multiplier
	logic signed [W-1:0]      opa_s1;

	logic en;
	logic skid_q;
	logic [39:0] skid_data_q;

	assign en       = !skid_q;
	assign s_tready = en;

	// stage 1: operand prep, add and subtract
	logic signed [W-1:0] in_a, in_b;
	logic signed [W:0]   sum_w;
	logic [W-1:0]        abs_a, abs_b;
	fpalu_pkg::cmd_t     in_cmd;
	logic signed [W-1:0] res_in;
	fpalu_pkg::status_t  st_in;

	assign in_a   = s_tdata[31:0];
	assign in_b   = s_tdata[63:32];
	assign in_cmd = fpalu_pkg::cmd_t'(s_tuser);
	assign abs_a  = in_a[W-1] ? (W)'(-in_a) : in_a;
	assign abs_b  = in_b[W-1] ? (W)'(-in_b) : in_b;

	always_comb begin
		sum_w  = '0;
		res_in = '0;
		st_in  = fpalu_pkg::ST_OK;
		case (in_cmd)
			fpalu_pkg::CMD_ADD, fpalu_pkg::CMD_SUB: begin
				if (in_cmd == fpalu_pkg::CMD_ADD)
					sum_w = {in_a[W-1], in_a} + {in_b[W-1], in_b};
				else
					sum_w = {in_a[W-1], in_a} - {in_b[W-1], in_b};
				// overflow when the two top bits disagree
				if (sum_w[W] != sum_w[W-1]) begin
					st_in  = fpalu_pkg::ST_SAT;
					res_in = sum_w[W] ? fpalu_pkg::WORD_MIN : fpalu_pkg::WORD_MAX;
				end else begin
					res_in = sum_w[W-1:0];
				end
			end
			fpalu_pkg::CMD_DIV: begin
				if (in_b == '0)
					st_in = fpalu_pkg::ST_DIV_ZERO;
			end
			fpalu_pkg::CMD_ROOT: begin
				if (in_a[W-1])
					st_in = fpalu_pkg::ST_NEG_ROOT;
			end
			default: begin
				res_in = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s[1]   <= in_cmd;
			res_s[1]   <= res_in;
			st_s[1]    <= st_in;
			mb_s1      <= (in_cmd == fpalu_pkg::CMD_SQUARE) ? in_a : in_b;
			opa_s1     <= in_a;
			drem_s[1]  <= '0;
			dnq_s[1]   <= {abs_a, {FRACTION_BITS{1'b0}}};
			dden_s[1]  <= abs_b;
			dneg_s[1]  <= in_a[W-1] ^ in_b[W-1];
			srem_s[1]  <= '0;
			sroot_s[1] <= '0;
			snum_s[1]  <= {{(2*SW-W){1'b0}}, in_a} << FRACTION_BITS;
		end
	end

	// stage 2: product of the multiply and square commands
	always_ff @(posedge clk) begin
		if (en)
			prod_s2 <= mb_s1 * opa_s1;
	end

	// floor shift and saturation of the product, used in stage 3
	logic signed [2*W-FRACTION_BITS-1:0] shifted;
	logic signed [W-1:0] mul_res;
	logic                mul_sat;
	assign shifted = prod_s2[2*W-1:FRACTION_BITS];
	always_comb begin
		mul_sat = 1'b0;
		mul_res = shifted[W-1:0];
		if (shifted > $signed((2*W-FRACTION_BITS)'(fpalu_pkg::WORD_MAX))) begin
			mul_sat = 1'b1;
			mul_res = fpalu_pkg::WORD_MAX;
		end else if (shifted < $signed({{(W-FRACTION_BITS){1'b1}}, fpalu_pkg::WORD_MIN})) begin
			mul_sat = 1'b1;
			mul_res = fpalu_pkg::WORD_MIN;
		end
	end

	// iteration stages: one quotient bit and, early on, one root bit each
	for (genvar k = 2; k <= L + 1; k++) begin : g_step
		logic [W:0]      dt;
		logic            dbit;
		logic [SW+3:0]   stv;
		logic [SW+3:0]   trial;
		logic            sbit;

		assign dt    = {drem_s[k-1], dnq_s[k-1][DW-1]};
		assign dbit  = dt >= {1'b0, dden_s[k-1]};
		assign stv   = {srem_s[k-1], snum_s[k-1][2*SW-1 -: 2]};
		assign trial = {2'b00, sroot_s[k-1], 2'b01};
		assign sbit  = stv >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cmd_s[k]  <= cmd_s[k-1];
				dden_s[k] <= dden_s[k-1];
				dneg_s[k] <= dneg_s[k-1];
				drem_s[k] <= dbit ? (W)'(dt - {1'b0, dden_s[k-1]}) : dt[W-1:0];
				dnq_s[k]  <= {dnq_s[k-1][DW-2:0], dbit};
				if (k == 3 && (cmd_s[k-1] == fpalu_pkg::CMD_MUL ||
						cmd_s[k-1] == fpalu_pkg::CMD_SQUARE)) begin
					res_s[k] <= mul_res;
					st_s[k]  <= mul_sat ? fpalu_pkg::ST_SAT : fpalu_pkg::ST_OK;
				end else begin
					res_s[k] <= res_s[k-1];
					st_s[k]  <= st_s[k-1];
				end
				if (k - 2 < SW) begin
					srem_s[k]  <= sbit ? (SW+2)'(stv - trial) : stv[SW+1:0];
					sroot_s[k] <= {sroot_s[k-1][SW-2:0], sbit};
					snum_s[k]  <= snum_s[k-1] << 2;
				end else begin
					srem_s[k]  <= srem_s[k-1];
					sroot_s[k] <= sroot_s[k-1];
					snum_s[k]  <= snum_s[k-1];
				end
			end
		end
	end

	// last stage: sign and saturation of the quotient, pick the result
	logic [DW-1:0]       q;
	logic signed [W-1:0] fin_res;
	fpalu_pkg::status_t  fin_st;
	assign q = dnq_s[L+1];

	always_comb begin
		fin_res = res_s[L+1];
		fin_st  = st_s[L+1];
		case (cmd_s[L+1])
			fpalu_pkg::CMD_DIV: begin
				if (st_s[L+1] == fpalu_pkg::ST_DIV_ZERO) begin
					fin_res = '0;
				end else if (dneg_s[L+1]) begin
					if (q > (DW)'(64'h8000_0000)) begin
						fin_res = fpalu_pkg::WORD_MIN;
						fin_st  = fpalu_pkg::ST_SAT;
					end else begin
						fin_res = (W)'(-q[W-1:0]);
					end
				end else begin
					if (q > (DW)'(64'h7fff_ffff)) begin
						fin_res = fpalu_pkg::WORD_MAX;
						fin_st  = fpalu_pkg::ST_SAT;
					end else begin
						fin_res = q[W-1:0];
					end
				end
			end
			fpalu_pkg::CMD_ROOT: begin
				if (st_s[L+1] == fpalu_pkg::ST_NEG_ROOT)
					fin_res = '0;
				else
					fin_res = {{(W-SW){1'b0}}, sroot_s[L+1]};
			end
			default: begin
				fin_res = res_s[L+1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[N] <= 1'b0;
		end else if (en) begin
			vld_s[N] <= vld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s[N]   <= fin_res;
			st_s[N]    <= fin_st;
			cmd_s[N]   <= cmd_s[N-1];
			drem_s[N]  <= drem_s[N-1];
			dnq_s[N]   <= dnq_s[N-1];
			dden_s[N]  <= dden_s[N-1];
			dneg_s[N]  <= dneg_s[N-1];
			srem_s[N]  <= srem_s[N-1];
			sroot_s[N] <= sroot_s[N-1];
			snum_s[N]  <= snum_s[N-1];
		end
	end

	// output skid register
	logic [39:0] out_beat;
	assign out_beat = {6'd0, st_s[N], res_s[N]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (m_tready)
				skid_q <= 1'b0;
		end else if (vld_s[N] && !m_tready) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q && vld_s[N] && !m_tready)
			skid_data_q <= out_beat;
	end

	assign m_tvalid = skid_q || vld_s[N];
	assign m_tdata  = skid_q ? skid_data_q : out_beat;

endmodule

>>> rtl/core/fpalu_checker.sv
// ----------------------------------------------------------------------------
// fpalu_checker
// port level checks of the fixed point alu, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpalu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic [1:0]  m_status;
	logic [31:0] m_value;

	assign m_status = m_tdata[33:32];
	assign m_value  = m_tdata[31:0];

	// a result waiting for the sink stays put
	`ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

	// error statuses always carry a zero result
	`ASSERT_NEVER(a_divz_zero, m_tvalid && m_status == fpalu_pkg::ST_DIV_ZERO && m_value != '0)
	`ASSERT_NEVER(a_negr_zero, m_tvalid && m_status == fpalu_pkg::ST_NEG_ROOT && m_value != '0)

	// saturated results sit at a range limit
	`ASSERT_NEVER(a_sat_limit, m_tvalid && m_status == fpalu_pkg::ST_SAT && m_value != 32'h7fff_ffff && m_value != 32'h8000_0000)

endmodule

bind fixed_point_calculator_alu fpalu_checker u_fpalu_checker (.*);
